/* hw/rtl/dcs_pkg.sv */
// Package with shared types and constants of the discrete CDF sampler.
package dcs_pkg;
	localparam logic [1:0] CMD_CLEAR     = 2'd0;
	localparam logic [1:0] CMD_APPEND    = 2'd1;
	localparam logic [1:0] CMD_NORMALIZE = 2'd2;
	localparam logic [1:0] CMD_SAMPLE    = 2'd3;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam int TABLE_BITS = 34;
	localparam int SAMPLE_BITS = 25;
	typedef logic [TABLE_BITS-1:0] entry_t;
	typedef struct packed {
		logic   start;
		entry_t num;
		entry_t den;
	} div_req_t;
	typedef struct packed {
		logic   done;
		entry_t quo;
	} div_rsp_t;
endpackage

/* hw/rtl/dcs_divider.sv */
// Bit-serial divider computing floor(num * 2^FRAC / den) for num <= den.
module dcs_divider #(
	parameter int FRAC = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dcs_pkg::div_req_t req,
	output dcs_pkg::div_rsp_t rsp
);
	localparam int CW = $clog2(FRAC + 2);
	localparam int RW = dcs_pkg::TABLE_BITS + 1;
	logic [RW-1:0] rem_q;
	logic [dcs_pkg::TABLE_BITS-1:0] den_q, quo_q;
	logic [CW-1:0] cnt_q;
	logic run_q, done_q;
	logic [RW-1:0] sh;
	assign sh = {rem_q[RW-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(FRAC - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			if (req.num >= req.den) begin
				quo_q <= dcs_pkg::TABLE_BITS'(1);
				rem_q <= {1'b0, req.num - req.den};
			end else begin
				quo_q <= '0;
				rem_q <= {1'b0, req.num};
			end
		end else if (run_q) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= sh - {1'b0, den_q};
				quo_q <= {quo_q[dcs_pkg::TABLE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[dcs_pkg::TABLE_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

/* hw/rtl/discrete_cdf_sampler_unit.sv */
// Top level of the discrete CDF sampler: table memory and command sequencer.
// Channel | Ports                                   | Handshake
// request | cmd, weight, sample_value               | start && !busy
// result  | index, pdf, total, count, is_normalized, status | done, one cycle
// Clear goes straight to done; append reads the last entry, writes it plus
// the weight, saturating; sample does a binary search and reads two entries.
// Normalize reads the total, then divides each entry by it in the divider.
// Reset clears count, total and flag; entry zero always reads as zero.
// busy is high from acceptance to the done cycle; the receiver cannot stall.
module discrete_cdf_sampler_unit #(
	parameter int MAX_ENTRIES = 1024,
	parameter int WEIGHT_BITS = 24,
	parameter int PROB_FRAC_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [WEIGHT_BITS-1:0]        weight,
	input  logic [dcs_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic                          done,
	output logic [$clog2(MAX_ENTRIES)-1:0] index,
	output logic [dcs_pkg::TABLE_BITS-1:0] pdf,
	output logic [dcs_pkg::TABLE_BITS-1:0] total,
	output logic [$clog2(MAX_ENTRIES+1)-1:0] count,
	output logic                          is_normalized,
	output logic [1:0]                    status
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int AW = $clog2(MAX_ENTRIES + 1);
	localparam int TW = dcs_pkg::TABLE_BITS;
	localparam logic [TW-1:0] TMAX = '1;
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_APW = 4'd2,
		S_NRD = 4'd3, S_NDIV = 4'd4, S_NWAIT = 4'd5, S_BS = 4'd6,
		S_BSW = 4'd7, S_PR0 = 4'd8, S_PR1 = 4'd9, S_PR2 = 4'd10, S_DONE = 4'd11,
		S_NTOT = 4'd12;

	logic [TW-1:0] mem [0:MAX_ENTRIES];
	logic [AW-1:0] raddr, waddr;
	logic we;
	logic [TW-1:0] wdata, rdata_q;
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= (raddr == '0) ? '0 : mem[raddr];
	end

	logic [3:0] st_q;
	logic [1:0] cmd_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [dcs_pkg::SAMPLE_BITS-1:0] sv_q;
	logic [AW-1:0] cnt_q, ptr_q, lo_q, hi_q, mid;
	logic [TW-1:0] tot_q, a_q;
	logic norm_q;
	logic [IW-1:0] idx_q;
	logic [TW-1:0] pdf_q;
	logic [1:0] stat_q;
	logic done_q;
	logic [TW:0] sum;
	dcs_pkg::div_req_t dreq;
	dcs_pkg::div_rsp_t drsp;

	dcs_divider #(.FRAC(PROB_FRAC_BITS)) u_div (.clk(clk), .arst_n(arst_n),
		.req(dreq), .rsp(drsp));

	assign mid = AW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));
	assign sum = {1'b0, rdata_q} + (TW+1)'(w_q);

	always_comb begin
		raddr = ptr_q;
		if (st_q == S_BS) raddr = mid;
		we = 1'b0;
		waddr = ptr_q;
		wdata = rdata_q;
		dreq.start = 1'b0;
		dreq.num = rdata_q;
		dreq.den = tot_q;
		case (st_q)
			S_APW: begin
				we = 1'b1;
				waddr = ptr_q + 1'b1;
				wdata = sum[TW] ? TMAX : sum[TW-1:0];
			end
			S_NDIV: dreq.start = 1'b1;
			S_NWAIT: begin
				if (drsp.done) begin
					we = 1'b1;
					wdata = (ptr_q == cnt_q) ? TW'(64'd1 << PROB_FRAC_BITS) : drsp.quo;
				end
			end
			default: ;
		endcase
		if (st_q == S_IDLE && start && cmd == dcs_pkg::CMD_CLEAR) begin
			we = 1'b1;
			waddr = '0;
			wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			tot_q <= '0;
			norm_q <= 1'b0;
			done_q <= 1'b0;
			ptr_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			cmd_q <= '0;
			a_q <= '0;
			idx_q <= '0;
			pdf_q <= '0;
			stat_q <= dcs_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						stat_q <= dcs_pkg::ST_OK;
						idx_q <= '0;
						pdf_q <= '0;
						ptr_q <= cnt_q;
						case (cmd)
							dcs_pkg::CMD_CLEAR: begin
								cnt_q <= '0;
								norm_q <= 1'b0;
								st_q <= S_DONE;
							end
							dcs_pkg::CMD_APPEND: begin
								if (cnt_q >= AW'(MAX_ENTRIES)) begin
									stat_q <= dcs_pkg::ST_FULL;
									st_q <= S_DONE;
								end else st_q <= S_RD;
							end
							dcs_pkg::CMD_NORMALIZE: st_q <= S_RD;
							default: begin
								if (cnt_q == '0) begin
									stat_q <= dcs_pkg::ST_EMPTY;
									st_q <= S_DONE;
								end else begin
									lo_q <= '0;
									hi_q <= cnt_q + 1'b1;
									st_q <= S_BS;
								end
							end
						endcase
					end
				end
				S_RD: st_q <= (cmd_q == dcs_pkg::CMD_APPEND) ? S_APW : S_NTOT;
				S_APW: begin
					ptr_q <= ptr_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					st_q <= S_DONE;
				end
				S_NTOT: begin
					tot_q <= rdata_q;
					if (rdata_q == '0) st_q <= S_DONE;
					else begin
						norm_q <= 1'b1;
						ptr_q <= AW'(1);
						st_q <= S_NRD;
					end
				end
				S_NRD: st_q <= S_NDIV;
				S_NDIV: st_q <= S_NWAIT;
				S_NWAIT: begin
					if (drsp.done) begin
						if (ptr_q == cnt_q) st_q <= S_DONE;
						else begin
							ptr_q <= ptr_q + 1'b1;
							st_q <= S_NRD;
						end
					end
				end
				S_BS: begin
					if (lo_q == hi_q) begin
						ptr_q <= (lo_q == '0) ? '0 :
							((lo_q - 1'b1 > cnt_q - 1'b1) ? cnt_q - 1'b1 : lo_q - 1'b1);
						st_q <= S_PR0;
					end else st_q <= S_BSW;
				end
				S_BSW: begin
					if ({{(TW-dcs_pkg::SAMPLE_BITS){1'b0}}, sv_q} <= rdata_q) hi_q <= mid;
					else lo_q <= mid + 1'b1;
					st_q <= S_BS;
				end
				S_PR0: begin
					idx_q <= IW'(ptr_q);
					ptr_q <= ptr_q + 1'b1;
					st_q <= S_PR1;
				end
				S_PR1: begin
					a_q <= rdata_q;
					st_q <= S_PR2;
				end
				S_PR2: begin
					pdf_q <= rdata_q - a_q;
					st_q <= S_DONE;
				end
				default: begin
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			w_q <= weight;
			sv_q <= sample_value;
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign index = idx_q;
	assign pdf = pdf_q;
	assign total = tot_q;
	assign count = cnt_q;
	assign is_normalized = norm_q;
	assign status = stat_q;
endmodule

/* hw/rtl/dcs_checker.sv */
// Port-level checker of the discrete CDF sampler, bound to the top level.
module dcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after request");
	a_done_prev: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3)) else $error("bad status");
endmodule

bind discrete_cdf_sampler_unit dcs_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .status(status));
